// ----- rtl/cjm_pkg.sv -----
// Shared definitions for the circular journal manager: sizes, slot status codes,
// request kinds, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package cjm_pkg;

    localparam int DEPTH        = 64;
    localparam int PAYLOAD_BITS = 64;

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KIND_W = 2;
    localparam int OFF_W  = 7;
    localparam int WORD_W = 64;

    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [IDX_W:0]          idx_sum_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [OFF_W-1:0]        off_t;
    typedef logic [PAYLOAD_BITS-1:0] text_t;
    typedef logic [WORD_W-1:0]       word_t;
    typedef logic [2:0]              slot_code_t;

    // Slot status codes.
    localparam slot_code_t SLOT_EMPTY    = 3'd0;
    localparam slot_code_t SLOT_HEAD     = 3'd1;
    localparam slot_code_t SLOT_LIVE_A   = 3'd2;
    localparam slot_code_t SLOT_DEL_A    = 3'd3;
    localparam slot_code_t SLOT_LIVE_B   = 3'd4;
    localparam slot_code_t SLOT_DEL_B    = 3'd5;
    localparam slot_code_t SLOT_DEL_HEAD = 3'd6;

    // Request kinds.
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VIEW   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AP_START,
        S_AP_TAIL,
        S_AP_NEW,
        S_AP_HEAD,
        S_DEL_START,
        S_DEL_CHECK,
        S_VIEW_REDUCE,
        S_VIEW_EMIT,
        S_CLEAR,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        RD_TAIL,
        RD_TAIL_NEXT,
        RD_HEAD_NEXT,
        RD_HEAD_OFF,
        RD_ADDR_NEXT
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_ZERO,
        WR_TAIL,
        WR_TAIL_NEXT,
        WR_HEAD,
        WR_ADDR
    } wr_sel_t;

    typedef enum logic [2:0] {
        CODE_HEAD,
        CODE_LIVE_A,
        CODE_LAP,
        CODE_NEW_HEAD,
        CODE_DELETE
    } code_sel_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_NEXT
    } ptr_op_t;

    typedef enum logic [1:0] {
        ADDR_HOLD,
        ADDR_HEAD_OFF,
        ADDR_NEXT
    } addr_op_t;

    typedef struct packed {
        logic      req_ready;
        logic      off_reduce;
        logic      rd_en;
        rd_sel_t   rd_sel;
        logic      st_we;
        logic      tx_we;
        wr_sel_t   wr_sel;
        code_sel_t code_sel;
        ptr_op_t   head_op;
        ptr_op_t   tail_op;
        logic      empty_set;
        logic      empty_clr;
        logic      wipe;
        logic      lap_load;
        addr_op_t  addr_op;
        logic      rows_dec;
        logic      emit_done;
        logic      emit_row;
        logic      err;
    } cjm_cmd_t;

    typedef struct packed {
        logic              req_valid;
        logic [KIND_W-1:0] req_kind;
        logic              empty;
        logic              head_eq_tail;
        logic              off_ge_depth;
        slot_code_t        rd_status;
        logic              out_free;
        logic              last_row;
    } cjm_status_t;

    function automatic idx_t wrap_next(input idx_t i);
        idx_t r;
        if (i == idx_t'(DEPTH - 1)) begin
            r = '0;
        end
        else begin
            r = i + idx_t'(1);
        end
        return r;
    endfunction

    function automatic slot_code_t delete_code(input slot_code_t c);
        slot_code_t r;
        case (c)
            SLOT_HEAD:   r = SLOT_DEL_HEAD;
            SLOT_LIVE_A: r = SLOT_DEL_A;
            SLOT_LIVE_B: r = SLOT_DEL_B;
            default:     r = c;
        endcase
        return r;
    endfunction

    function automatic logic is_live(input slot_code_t c);
        return (c == SLOT_HEAD) || (c == SLOT_LIVE_A) || (c == SLOT_LIVE_B);
    endfunction

endpackage

// ----- rtl/cjm_req_if.sv -----
// Request channel of the circular journal manager: valid, ready and the item fields.
// Depends on cjm_pkg.
`timescale 1ns / 1ps

interface cjm_req_if;
    logic                      valid;
    logic                      ready;
    logic [cjm_pkg::KIND_W-1:0] kind;
    cjm_pkg::word_t            payload;
    cjm_pkg::off_t             row_offset;
    logic [6:0]                count;

    modport source (output valid, output kind, output payload, output row_offset,
                    output count, input ready);
    modport sink   (input valid, input kind, input payload, input row_offset,
                    input count, output ready);
endinterface

// ----- rtl/cjm_rsp_if.sv -----
// Result channel of the circular journal manager: valid, ready and the result fields.
// Depends on cjm_pkg.
`timescale 1ns / 1ps

interface cjm_rsp_if;
    logic           valid;
    logic           ready;
    logic           status_code;
    cjm_pkg::word_t row_payload;
    logic           row_visible;
    logic           last_result;

    modport source (output valid, output status_code, output row_payload,
                    output row_visible, output last_result, input ready);
    modport sink   (input valid, input status_code, input row_payload,
                    input row_visible, input last_result, output ready);
endinterface

// ----- rtl/cjm_datapath.sv -----
// Datapath of the circular journal manager: pointers, slot memories, item
// registers and the result register. Depends on cjm_pkg, cjm_req_if, cjm_rsp_if.
`timescale 1ns / 1ps

module cjm_datapath (
    input  logic                clk,
    input  logic                rst_n,
    cjm_req_if.sink             req,
    cjm_rsp_if.source           rsp,
    input  cjm_pkg::cjm_cmd_t   cmd,
    output cjm_pkg::cjm_status_t stat
);

    cjm_pkg::idx_t       head_reg;
    cjm_pkg::idx_t       tail_reg;
    cjm_pkg::idx_t       addr_reg;
    logic                empty_reg;
    cjm_pkg::off_t       off_reg;
    cjm_pkg::cnt_t       rows_reg;
    cjm_pkg::text_t      pay_reg;
    logic [cjm_pkg::KIND_W-1:0] kind_reg;
    cjm_pkg::slot_code_t lap_reg;

    cjm_pkg::slot_code_t status_mem [cjm_pkg::DEPTH];
    cjm_pkg::text_t      text_mem   [cjm_pkg::DEPTH];
    logic [cjm_pkg::DEPTH-1:0] valid_reg;

    cjm_pkg::slot_code_t rd_status_reg;
    cjm_pkg::text_t      rd_text_reg;

    logic                out_valid_reg;
    logic                out_err_reg;
    cjm_pkg::word_t      out_payload_reg;
    logic                out_vis_reg;
    logic                out_last_reg;

    logic                load;
    logic                out_free;
    logic                rd_vis;
    cjm_pkg::idx_t       head_next_idx;
    cjm_pkg::idx_t       tail_next_idx;
    cjm_pkg::idx_t       addr_next_idx;
    cjm_pkg::idx_t       head_off_idx;
    cjm_pkg::idx_sum_t   head_off_sum;
    cjm_pkg::idx_t       rd_addr;
    cjm_pkg::idx_t       wr_addr;
    cjm_pkg::slot_code_t wr_code;
    cjm_pkg::slot_code_t lap_base;

    assign load     = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = cmd.req_ready;

    assign head_next_idx = cjm_pkg::wrap_next(head_reg);
    assign tail_next_idx = cjm_pkg::wrap_next(tail_reg);
    assign addr_next_idx = cjm_pkg::wrap_next(addr_reg);

    // The offset is below DEPTH whenever this sum is used, so one subtract wraps it.
    always_comb
    begin
        head_off_sum = {1'b0, head_reg} + {1'b0, off_reg[cjm_pkg::IDX_W-1:0]};
        if (head_off_sum >= cjm_pkg::idx_sum_t'(cjm_pkg::DEPTH)) begin
            head_off_idx = cjm_pkg::idx_t'(head_off_sum - cjm_pkg::idx_sum_t'(cjm_pkg::DEPTH));
        end
        else begin
            head_off_idx = head_off_sum[cjm_pkg::IDX_W-1:0];
        end
    end

    always_comb
    begin
        case (cmd.rd_sel)
            cjm_pkg::RD_TAIL:      rd_addr = tail_reg;
            cjm_pkg::RD_TAIL_NEXT: rd_addr = tail_next_idx;
            cjm_pkg::RD_HEAD_NEXT: rd_addr = head_next_idx;
            cjm_pkg::RD_HEAD_OFF:  rd_addr = head_off_idx;
            cjm_pkg::RD_ADDR_NEXT: rd_addr = addr_next_idx;
            default:               rd_addr = tail_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.wr_sel)
            cjm_pkg::WR_ZERO:      wr_addr = '0;
            cjm_pkg::WR_TAIL:      wr_addr = tail_reg;
            cjm_pkg::WR_TAIL_NEXT: wr_addr = tail_next_idx;
            cjm_pkg::WR_HEAD:      wr_addr = head_reg;
            cjm_pkg::WR_ADDR:      wr_addr = addr_reg;
            default:               wr_addr = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.code_sel)
            cjm_pkg::CODE_HEAD:     wr_code = cjm_pkg::SLOT_HEAD;
            cjm_pkg::CODE_LIVE_A:   wr_code = cjm_pkg::SLOT_LIVE_A;
            cjm_pkg::CODE_LAP:      wr_code = lap_reg;
            cjm_pkg::CODE_NEW_HEAD:
                wr_code = (rd_status_reg == cjm_pkg::SLOT_DEL_A ||
                           rd_status_reg == cjm_pkg::SLOT_DEL_B) ?
                          cjm_pkg::SLOT_DEL_HEAD : cjm_pkg::SLOT_HEAD;
            cjm_pkg::CODE_DELETE:   wr_code = cjm_pkg::delete_code(rd_status_reg);
            default:                wr_code = cjm_pkg::SLOT_EMPTY;
        endcase
    end

    // Lap code of the previous tail, flipped when the tail wraps to slot zero.
    always_comb
    begin
        lap_base = (rd_status_reg == cjm_pkg::SLOT_LIVE_A ||
                    rd_status_reg == cjm_pkg::SLOT_DEL_A) ?
                   cjm_pkg::SLOT_LIVE_A : cjm_pkg::SLOT_LIVE_B;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            valid_reg <= '0;
        end
        else begin
            case (cmd.head_op)
                cjm_pkg::PTR_ZERO: head_reg <= '0;
                cjm_pkg::PTR_NEXT: head_reg <= head_next_idx;
                default:           head_reg <= head_reg;
            endcase
            case (cmd.tail_op)
                cjm_pkg::PTR_ZERO: tail_reg <= '0;
                cjm_pkg::PTR_NEXT: tail_reg <= tail_next_idx;
                default:           tail_reg <= tail_reg;
            endcase
            if (cmd.empty_set) begin
                empty_reg <= 1'b1;
            end
            else if (cmd.empty_clr) begin
                empty_reg <= 1'b0;
            end
            if (cmd.wipe) begin
                valid_reg <= '0;
            end
            else if (cmd.st_we) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            kind_reg <= req.kind;
            pay_reg  <= req.payload[cjm_pkg::PAYLOAD_BITS-1:0];
            off_reg  <= req.row_offset;
            if (req.count == 7'd0 || req.count > 7'(cjm_pkg::DEPTH)) begin
                rows_reg <= cjm_pkg::cnt_t'(cjm_pkg::DEPTH);
            end
            else begin
                rows_reg <= req.count[cjm_pkg::CNT_W-1:0];
            end
        end
        else begin
            if (cmd.off_reduce) begin
                off_reg <= off_reg - cjm_pkg::off_t'(cjm_pkg::DEPTH);
            end
            if (cmd.rows_dec) begin
                rows_reg <= rows_reg - cjm_pkg::cnt_t'(1);
            end
        end
        if (cmd.lap_load) begin
            if (tail_reg == cjm_pkg::idx_t'(cjm_pkg::DEPTH - 1)) begin
                lap_reg <= (lap_base == cjm_pkg::SLOT_LIVE_A) ?
                           cjm_pkg::SLOT_LIVE_B : cjm_pkg::SLOT_LIVE_A;
            end
            else begin
                lap_reg <= lap_base;
            end
        end
        case (cmd.addr_op)
            cjm_pkg::ADDR_HEAD_OFF: addr_reg <= head_off_idx;
            cjm_pkg::ADDR_NEXT:     addr_reg <= addr_next_idx;
            default:                addr_reg <= addr_reg;
        endcase
    end

    // Slot memories: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.st_we) begin
            status_mem[wr_addr] <= wr_code;
        end
        if (cmd.tx_we) begin
            text_mem[wr_addr] <= pay_reg;
        end
        if (cmd.rd_en) begin
            rd_status_reg <= valid_reg[rd_addr] ? status_mem[rd_addr] : cjm_pkg::SLOT_EMPTY;
            rd_text_reg   <= text_mem[rd_addr];
        end
    end

    assign rd_vis = cjm_pkg::is_live(rd_status_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_done || cmd.emit_row) begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_done) begin
            out_err_reg     <= cmd.err;
            out_payload_reg <= '0;
            out_vis_reg     <= 1'b0;
            out_last_reg    <= 1'b1;
        end
        else if (cmd.emit_row) begin
            out_err_reg     <= 1'b0;
            out_payload_reg <= rd_vis ? cjm_pkg::word_t'(rd_text_reg) : '0;
            out_vis_reg     <= rd_vis;
            out_last_reg    <= (rows_reg == cjm_pkg::cnt_t'(1));
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status_code = out_err_reg;
    assign rsp.row_payload = out_payload_reg;
    assign rsp.row_visible = out_vis_reg;
    assign rsp.last_result = out_last_reg;

    assign stat.req_valid    = req.valid;
    assign stat.req_kind     = (load) ? req.kind : kind_reg;
    assign stat.empty        = empty_reg;
    assign stat.head_eq_tail = (head_reg == tail_reg);
    assign stat.off_ge_depth = (off_reg >= cjm_pkg::off_t'(cjm_pkg::DEPTH));
    assign stat.rd_status    = rd_status_reg;
    assign stat.out_free     = out_free;
    assign stat.last_row     = (rows_reg == cjm_pkg::cnt_t'(1));

endmodule

// ----- rtl/cjm_ctrl.sv -----
// Controller of the circular journal manager: sequences each request through
// the datapath by command and status structs. Depends on cjm_pkg.
`timescale 1ns / 1ps

module cjm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cjm_pkg::cjm_status_t stat,
    output cjm_pkg::cjm_cmd_t    cmd
);

    cjm_pkg::state_t state_reg;
    cjm_pkg::state_t state_next;
    logic            err_reg;
    logic            err_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= cjm_pkg::S_IDLE;
            err_reg   <= 1'b0;
        end
        else begin
            state_reg <= state_next;
            err_reg   <= err_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        err_next   = err_reg;
        case (state_reg)
            cjm_pkg::S_IDLE:
            begin
                if (stat.req_valid) begin
                    err_next = 1'b0;
                    case (stat.req_kind)
                        cjm_pkg::KIND_APPEND: state_next = cjm_pkg::S_AP_START;
                        cjm_pkg::KIND_DELETE: state_next = cjm_pkg::S_DEL_START;
                        cjm_pkg::KIND_VIEW:   state_next = cjm_pkg::S_VIEW_REDUCE;
                        default:              state_next = cjm_pkg::S_CLEAR;
                    endcase
                end
            end
            cjm_pkg::S_AP_START:
            begin
                if (stat.empty || stat.head_eq_tail) begin
                    state_next = cjm_pkg::S_DONE;
                end
                else begin
                    state_next = cjm_pkg::S_AP_TAIL;
                end
            end
            cjm_pkg::S_AP_TAIL:
                state_next = cjm_pkg::S_AP_NEW;
            cjm_pkg::S_AP_NEW:
            begin
                if (stat.rd_status == cjm_pkg::SLOT_EMPTY) begin
                    state_next = cjm_pkg::S_DONE;
                end
                else begin
                    state_next = cjm_pkg::S_AP_HEAD;
                end
            end
            cjm_pkg::S_AP_HEAD:
                state_next = cjm_pkg::S_DONE;
            cjm_pkg::S_DEL_START:
            begin
                if (stat.off_ge_depth) begin
                    err_next   = 1'b1;
                    state_next = cjm_pkg::S_DONE;
                end
                else begin
                    state_next = cjm_pkg::S_DEL_CHECK;
                end
            end
            cjm_pkg::S_DEL_CHECK:
            begin
                err_next   = !cjm_pkg::is_live(stat.rd_status);
                state_next = cjm_pkg::S_DONE;
            end
            cjm_pkg::S_VIEW_REDUCE:
            begin
                if (!stat.off_ge_depth) begin
                    state_next = cjm_pkg::S_VIEW_EMIT;
                end
            end
            cjm_pkg::S_VIEW_EMIT:
            begin
                if (stat.out_free && stat.last_row) begin
                    state_next = cjm_pkg::S_IDLE;
                end
            end
            cjm_pkg::S_CLEAR:
                state_next = cjm_pkg::S_DONE;
            cjm_pkg::S_DONE:
            begin
                if (stat.out_free) begin
                    state_next = cjm_pkg::S_IDLE;
                end
            end
            default:
                state_next = cjm_pkg::S_IDLE;
        endcase
    end

    // Commands.
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            cjm_pkg::S_IDLE:
                cmd.req_ready = 1'b1;
            cjm_pkg::S_AP_START:
            begin
                if (stat.empty) begin
                    cmd.st_we     = 1'b1;
                    cmd.tx_we     = 1'b1;
                    cmd.wr_sel    = cjm_pkg::WR_ZERO;
                    cmd.code_sel  = cjm_pkg::CODE_HEAD;
                    cmd.head_op   = cjm_pkg::PTR_ZERO;
                    cmd.tail_op   = cjm_pkg::PTR_ZERO;
                    cmd.empty_clr = 1'b1;
                end
                else if (stat.head_eq_tail) begin
                    cmd.st_we    = 1'b1;
                    cmd.tx_we    = 1'b1;
                    cmd.wr_sel   = cjm_pkg::WR_TAIL_NEXT;
                    cmd.code_sel = cjm_pkg::CODE_LIVE_A;
                    cmd.tail_op  = cjm_pkg::PTR_NEXT;
                end
                else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = cjm_pkg::RD_TAIL;
                end
            end
            cjm_pkg::S_AP_TAIL:
            begin
                cmd.lap_load = 1'b1;
                cmd.tail_op  = cjm_pkg::PTR_NEXT;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = cjm_pkg::RD_TAIL_NEXT;
            end
            cjm_pkg::S_AP_NEW:
            begin
                cmd.st_we  = 1'b1;
                cmd.tx_we  = 1'b1;
                cmd.wr_sel = cjm_pkg::WR_TAIL;
                if (stat.rd_status == cjm_pkg::SLOT_EMPTY) begin
                    cmd.code_sel = cjm_pkg::CODE_LIVE_A;
                end
                else begin
                    cmd.code_sel = cjm_pkg::CODE_LAP;
                    cmd.head_op  = cjm_pkg::PTR_NEXT;
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = cjm_pkg::RD_HEAD_NEXT;
                end
            end
            cjm_pkg::S_AP_HEAD:
            begin
                cmd.st_we    = 1'b1;
                cmd.wr_sel   = cjm_pkg::WR_HEAD;
                cmd.code_sel = cjm_pkg::CODE_NEW_HEAD;
            end
            cjm_pkg::S_DEL_START:
            begin
                if (!stat.off_ge_depth) begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = cjm_pkg::RD_HEAD_OFF;
                    cmd.addr_op = cjm_pkg::ADDR_HEAD_OFF;
                end
            end
            cjm_pkg::S_DEL_CHECK:
            begin
                cmd.st_we    = cjm_pkg::is_live(stat.rd_status);
                cmd.wr_sel   = cjm_pkg::WR_ADDR;
                cmd.code_sel = cjm_pkg::CODE_DELETE;
            end
            cjm_pkg::S_VIEW_REDUCE:
            begin
                if (stat.off_ge_depth) begin
                    cmd.off_reduce = 1'b1;
                end
                else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = cjm_pkg::RD_HEAD_OFF;
                    cmd.addr_op = cjm_pkg::ADDR_HEAD_OFF;
                end
            end
            cjm_pkg::S_VIEW_EMIT:
            begin
                if (stat.out_free) begin
                    cmd.emit_row = 1'b1;
                    if (!stat.last_row) begin
                        cmd.rows_dec = 1'b1;
                        cmd.rd_en    = 1'b1;
                        cmd.rd_sel   = cjm_pkg::RD_ADDR_NEXT;
                        cmd.addr_op  = cjm_pkg::ADDR_NEXT;
                    end
                end
            end
            cjm_pkg::S_CLEAR:
            begin
                cmd.wipe      = 1'b1;
                cmd.head_op   = cjm_pkg::PTR_ZERO;
                cmd.tail_op   = cjm_pkg::PTR_ZERO;
                cmd.empty_set = 1'b1;
            end
            cjm_pkg::S_DONE:
            begin
                cmd.emit_done = stat.out_free;
                cmd.err       = err_reg;
            end
            default:
                cmd = '0;
        endcase
    end

endmodule

// ----- rtl/circular_journal_manager.sv -----
// Top level of the circular journal manager: joins the controller and the datapath.
// Depends on cjm_pkg, cjm_req_if, cjm_rsp_if, cjm_ctrl and cjm_datapath.
`timescale 1ns / 1ps

// The journal is a ring of DEPTH slots, each holding a payload word and a
// status code. Requests arrive one transaction at a time on req and are
// worked on one at a time; req.ready is high only while the block is between
// requests, though a finished result may still be waiting on rsp. An append
// takes a different path from acceptance to its result, depending on
// whether the ring is empty, holds one entry, is still filling, or is full
// and overwrites its oldest slot; the path is set by the single registered
// read port of the status memory, which must be read for the tail, the new
// tail and the new head in turn. A delete whose row offset is DEPTH or more
// ends with an error without reading the ring; a clear empties the ring.
// A view first reduces a row offset of DEPTH or more below DEPTH, one
// subtraction of DEPTH at a time, then reads its start row and delivers one
// row transaction per cycle while rsp.ready stays high, with last_result set
// on the final row. Reset clears all slot status at once through per-slot
// valid bits, so no clearing pass is needed; payload storage is never read
// through a slot that was not written.

module circular_journal_manager (
    input  logic      clk,
    input  logic      rst_n,
    cjm_req_if.sink   req,
    cjm_rsp_if.source rsp
);

    cjm_pkg::cjm_cmd_t    cmd;
    cjm_pkg::cjm_status_t stat;

    // The controller decides each step; the datapath owns all storage and
    // both channels.
    cjm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    cjm_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

endmodule
